// ===== rtl/core/isjd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isjd_pkg
// Shared types and constants of the idle server job dispatcher.
// ----------------------------------------------------------------------------
package isjd_pkg;

    // default sizes, handed to the top level parameters
    localparam int NUM_SERVERS_DEF = 16;
    localparam int QUEUE_DEPTH_DEF = 256;

    // fixed field widths
    localparam int TIME_W   = 32;
    localparam int SRV_ID_W = 16;
    localparam int SIDX_W   = 4;
    localparam int SIU_W    = 5;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [SIU_W-1:0] SIU_RESET = SIU_W'(16);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_SERVER_ID = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SERVERS_IN_USE  = 1'b1;

    // request kinds
    localparam logic KIND_ARRIVAL     = 1'b0;
    localparam logic KIND_IDLE_NOTICE = 1'b1;

    // result status codes
    localparam logic STATUS_SENT    = 1'b0;
    localparam logic STATUS_DROPPED = 1'b1;

    // controller states
    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } ctl_state_t;

    // controller to datapath
    typedef struct packed {
        logic load;  // capture the incoming request
        logic exec;  // carry out the captured request
    } ctl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;  // result register can take a new result
    } dp_status_t;

endpackage

// ===== rtl/core/idle_server_job_dispatcher.sv =====
`timescale 1ns / 1ps
// A request is captured, then carried out once the result register is free;
// the result is registered. No new request is taken until the captured one
// is carried out, which waits while a stalled consumer holds a result.
// Reset: all servers idle, wait queue empty, configuration at its defaults;
// the queue storage itself is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// idle_server_job_dispatcher
// Hands jobs to the lowest idle server, else FIFO-queues or drops them.
// ----------------------------------------------------------------------------
module idle_server_job_dispatcher #(
    parameter int NUM_SERVERS = isjd_pkg::NUM_SERVERS_DEF,
    parameter int QUEUE_DEPTH = isjd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    output logic                              req_ready,
    input  logic                              kind,
    input  logic [isjd_pkg::TIME_W-1:0]       entry_time,
    input  logic [isjd_pkg::SIDX_W-1:0]       server_index,
    input  logic [isjd_pkg::TIME_W-1:0]       current_time,
    output logic                              rsp_valid,
    input  logic                              rsp_ready,
    output logic                              status,
    output logic [isjd_pkg::SRV_ID_W-1:0]     dest_server,
    output logic [isjd_pkg::TIME_W-1:0]       job_entry_time,
    output logic [isjd_pkg::TIME_W-1:0]       deliver_time,
    input  logic                              cfg_we,
    input  logic [isjd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [isjd_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import isjd_pkg::*;

    ctl_cmd_t   ctl_cmd;
    dp_status_t dp_status;

    // sequencing of requests
    isjd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .dp_status (dp_status),
        .ctl_cmd   (ctl_cmd)
    );

    // server flags, wait queue and result register
    isjd_datapath #(
        .NUM_SERVERS (NUM_SERVERS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctl_cmd        (ctl_cmd),
        .dp_status      (dp_status),
        .kind           (kind),
        .entry_time     (entry_time),
        .server_index   (server_index),
        .current_time   (current_time),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .rsp_valid      (rsp_valid),
        .rsp_ready      (rsp_ready),
        .status         (status),
        .dest_server    (dest_server),
        .job_entry_time (job_entry_time),
        .deliver_time   (deliver_time)
    );

endmodule

// ===== rtl/core/isjd_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isjd_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module isjd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/isjd_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isjd_ctrl
// Controller: takes one request, then runs it once the result register is free.
// ----------------------------------------------------------------------------
module isjd_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  isjd_pkg::dp_status_t  dp_status,
    output isjd_pkg::ctl_cmd_t    ctl_cmd
);
    import isjd_pkg::*;

    ctl_state_t state_reg;
    ctl_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next   = state_reg;
        req_ready    = 1'b0;
        ctl_cmd.load = 1'b0;
        ctl_cmd.exec = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    ctl_cmd.load = 1'b1;
                    state_next   = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (dp_status.out_free)
                begin
                    ctl_cmd.exec = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/isjd_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isjd_datapath
// Idle flags, wait queue, configuration registers and result register.
// ----------------------------------------------------------------------------
module isjd_datapath #(
    parameter int NUM_SERVERS = isjd_pkg::NUM_SERVERS_DEF,
    parameter int QUEUE_DEPTH = isjd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  isjd_pkg::ctl_cmd_t                ctl_cmd,
    output isjd_pkg::dp_status_t              dp_status,
    input  logic                              kind,
    input  logic [isjd_pkg::TIME_W-1:0]       entry_time,
    input  logic [isjd_pkg::SIDX_W-1:0]       server_index,
    input  logic [isjd_pkg::TIME_W-1:0]       current_time,
    input  logic                              cfg_we,
    input  logic [isjd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [isjd_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic                              rsp_valid,
    input  logic                              rsp_ready,
    output logic                              status,
    output logic [isjd_pkg::SRV_ID_W-1:0]     dest_server,
    output logic [isjd_pkg::TIME_W-1:0]       job_entry_time,
    output logic [isjd_pkg::TIME_W-1:0]       deliver_time
);
    import isjd_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int IDX_W = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1;

    // configuration registers
    logic [SRV_ID_W-1:0] first_id_reg;
    logic [SIU_W-1:0]    siu_reg;

    // captured request
    logic                kind_reg;
    logic [TIME_W-1:0]   entry_reg;
    logic [SIDX_W-1:0]   sidx_reg;
    logic [TIME_W-1:0]   now_reg;

    // server and queue state
    logic [NUM_SERVERS-1:0] idle_reg;
    logic [NUM_SERVERS-1:0] idle_next;
    logic [PTR_W-1:0]       rptr_reg;
    logic [PTR_W-1:0]       rptr_next;
    logic [PTR_W-1:0]       wptr_reg;
    logic [PTR_W-1:0]       wptr_next;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;

    // result register
    logic                rsp_valid_reg;
    logic                rsp_valid_next;
    logic                status_reg;
    logic [SRV_ID_W-1:0] dest_reg;
    logic [TIME_W-1:0]   job_time_reg;
    logic [TIME_W-1:0]   deliver_reg;

    // decode of the captured request
    logic [NUM_SERVERS-1:0] use_mask;
    logic [NUM_SERVERS-1:0] cand;
    logic [NUM_SERVERS-1:0] lowest;
    logic [IDX_W-1:0]       low_idx;
    logic                   srv_ok;
    logic                   q_nonempty;
    logic                   q_full;
    logic [TIME_W-1:0]      head_data;
    logic                   do_push;
    logic                   do_pop;
    logic                   has_result;
    logic                   res_status;
    logic [SRV_ID_W-1:0]    res_dest;
    logic [TIME_W-1:0]      res_job;

    // servers attached by configuration
    for (genvar i = 0; i < NUM_SERVERS; i++)
    begin : g_use
        assign use_mask[i] = (32'(i) < 32'(siu_reg));
    end

    // lowest idle server: isolate lowest set bit, then encode
    assign cand   = idle_reg & use_mask;
    assign lowest = cand & (~cand + NUM_SERVERS'(1));

    always_comb
    begin
        low_idx = '0;
        for (int i = 0; i < NUM_SERVERS; i++)
        begin
            if (lowest[i])
            begin
                low_idx = low_idx | IDX_W'(i);
            end
        end
    end

    assign srv_ok = (32'(sidx_reg) < 32'(siu_reg)) && (32'(sidx_reg) < NUM_SERVERS);
    assign q_nonempty = (count_reg != '0);
    assign q_full     = (count_reg == CNT_W'(QUEUE_DEPTH));

    // request decision
    always_comb
    begin
        idle_next  = idle_reg;
        do_push    = 1'b0;
        do_pop     = 1'b0;
        has_result = 1'b0;
        res_status = STATUS_SENT;
        res_dest   = '0;
        res_job    = '0;
        if (kind_reg == KIND_ARRIVAL)
        begin
            if (cand != '0)
            begin
                has_result = 1'b1;
                idle_next  = idle_reg & ~lowest;
                res_dest   = first_id_reg + SRV_ID_W'(low_idx);
                if (q_nonempty)
                begin
                    do_pop  = 1'b1;
                    do_push = 1'b1;
                    res_job = head_data;
                end
                else
                begin
                    res_job = entry_reg;
                end
            end
            else if (q_full)
            begin
                has_result = 1'b1;
                res_status = STATUS_DROPPED;
            end
            else
            begin
                do_push = 1'b1;
            end
        end
        else if (srv_ok)
        begin
            if (q_nonempty)
            begin
                do_pop     = 1'b1;
                has_result = 1'b1;
                res_dest   = first_id_reg + SRV_ID_W'(sidx_reg);
                res_job    = head_data;
            end
            else
            begin
                idle_next = idle_reg | (NUM_SERVERS'(1) << sidx_reg);
            end
        end
    end

    // queue pointer and fill count updates
    always_comb
    begin
        rptr_next  = rptr_reg;
        wptr_next  = wptr_reg;
        count_next = count_reg;
        if (ctl_cmd.exec)
        begin
            if (do_pop)
            begin
                rptr_next = (rptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
            end
            if (do_push)
            begin
                wptr_next = (wptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_next = count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_next = count_reg - 1'b1;
            end
        end
    end

    // result valid flag
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        if (ctl_cmd.exec && has_result)
        begin
            rsp_valid_next = 1'b1;
        end
    end

    assign dp_status.out_free = !rsp_valid_reg || rsp_ready;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_id_reg  <= '0;
            siu_reg       <= SIU_RESET;
            idle_reg      <= '1;
            rptr_reg      <= '0;
            wptr_reg      <= '0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we && cfg_index == CFG_FIRST_SERVER_ID)
            begin
                first_id_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == CFG_SERVERS_IN_USE)
            begin
                siu_reg <= cfg_data[SIU_W-1:0];
            end
            if (ctl_cmd.exec)
            begin
                idle_reg <= idle_next;
            end
            rptr_reg      <= rptr_next;
            wptr_reg      <= wptr_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // request capture and result payload
    always_ff @(posedge clk)
    begin
        if (ctl_cmd.load)
        begin
            kind_reg  <= kind;
            entry_reg <= entry_time;
            sidx_reg  <= server_index;
            now_reg   <= current_time;
        end
        if (ctl_cmd.exec && has_result)
        begin
            status_reg   <= res_status;
            dest_reg     <= res_dest;
            job_time_reg <= res_job;
            deliver_reg  <= (res_status == STATUS_DROPPED) ? '0 : now_reg + 1'b1;
        end
    end

    // wait queue storage, head read stays addressed by the read pointer
    isjd_ram #(
        .WIDTH (TIME_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_wait_ram (
        .clk   (clk),
        .we    (ctl_cmd.exec && do_push),
        .waddr (wptr_reg),
        .wdata (entry_reg),
        .raddr (rptr_reg),
        .rdata (head_data)
    );

    assign rsp_valid      = rsp_valid_reg;
    assign status         = status_reg;
    assign dest_server    = dest_reg;
    assign job_entry_time = job_time_reg;
    assign deliver_time   = deliver_reg;

endmodule
